### rtl/nearest_neighbour_route_order_defines.svh
// ----------------------------------------------------------------------------
// nearest neighbour route order - assertion macros
// shared helpers for concurrent checks on i_clk with synchronous i_rst_n
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOUR_ROUTE_ORDER_DEFINES_SVH
`define NEAREST_NEIGHBOUR_ROUTE_ORDER_DEFINES_SVH

// same-cycle implication
`define NNRO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NNRO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/nnro_pkg.sv
// ----------------------------------------------------------------------------
// nnro_pkg
// shared types and constants of the nearest neighbour route order block
// ----------------------------------------------------------------------------
package nnro_pkg;

    // width of the point index result field
    localparam int IDX_OUT_W = 6;

    // operations of the shared squared distance unit
    typedef enum logic [1:0] {
        DOP_HOLD   = 2'd0,
        DOP_FIRST  = 2'd1,
        DOP_SECOND = 2'd2
    } t_dist_op;

endpackage

### rtl/nnro_point_store.sv
// ----------------------------------------------------------------------------
// nnro_point_store
// point memory: one write port, one registered read port, x and y per entry
// ----------------------------------------------------------------------------
module nnro_point_store
    import nnro_pkg::*;
#(
    parameter int POINT_COUNT = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [$clog2(POINT_COUNT)-1:0]        i_waddr,
    input  logic signed [COORD_WIDTH-1:0]         i_wx,
    input  logic signed [COORD_WIDTH-1:0]         i_wy,
    input  logic [$clog2(POINT_COUNT)-1:0]        i_raddr,
    output logic signed [COORD_WIDTH-1:0]         o_rd_x,
    output logic signed [COORD_WIDTH-1:0]         o_rd_y
);

    logic [2*COORD_WIDTH-1:0] mem [POINT_COUNT];
    logic [2*COORD_WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wx, i_wy};
        end
        r_rd <= mem[i_raddr];
    end

    assign o_rd_x = r_rd[2*COORD_WIDTH-1:COORD_WIDTH];
    assign o_rd_y = r_rd[COORD_WIDTH-1:0];

endmodule

### rtl/nnro_sq_dist.sv
// ----------------------------------------------------------------------------
// nnro_sq_dist
// shared squarer: one axis per cycle unless i_op holds, sum of both squares on o_dist
// ----------------------------------------------------------------------------
module nnro_sq_dist
    import nnro_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  t_dist_op                      i_op,
    input  logic signed [COORD_WIDTH-1:0] i_a,
    input  logic signed [COORD_WIDTH-1:0] i_b,
    output logic [2*COORD_WIDTH:0]        o_dist
);

    logic signed [COORD_WIDTH:0] diff;
    logic [COORD_WIDTH:0]        neg;
    logic [COORD_WIDTH-1:0]      mag;
    logic [2*COORD_WIDTH-1:0]    sq;
    logic [2*COORD_WIDTH-1:0]    r_prod;
    logic [2*COORD_WIDTH-1:0]    r_acc;

    // exact absolute difference, fits in COORD_WIDTH bits unsigned
    assign diff = {i_a[COORD_WIDTH-1], i_a} - {i_b[COORD_WIDTH-1], i_b};
    assign neg  = -diff;
    assign mag  = diff[COORD_WIDTH] ? neg[COORD_WIDTH-1:0] : diff[COORD_WIDTH-1:0];
    assign sq   = mag * mag;

    always_ff @(posedge i_clk) begin
        case (i_op)
            DOP_HOLD: begin
            end
            DOP_FIRST: begin
                r_prod <= sq;
            end
            DOP_SECOND: begin
                r_acc  <= r_prod;
                r_prod <= sq;
            end
            default: begin
            end
        endcase
    end

    assign o_dist = {1'b0, r_acc} + {1'b0, r_prod};

endmodule

### rtl/nearest_neighbour_route_order.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_route_order
// greedy nearest neighbor visiting order over a loaded set of planar points
// ----------------------------------------------------------------------------
// usage
//   points go in on i_x_coord / i_y_coord, one item per cycle in which start
//   is high and busy is low; the item with i_is_last high closes the set
//   a loading item gives no result; points beyond POINT_COUNT are
//   dropped, a closing item still starts the ordering
//   after the closing item the block is busy and orders the N held points:
//   each route step scans all held points with one shared squaring unit,
//   an unvisited point going through read, square x, square y and compare,
//   a visited one through read alone, and then emits the chosen point
//   results come out on o_point_index / o_last_visit with a one-cycle o_valid
//   strobe, one per held point in visiting order, o_last_visit on the last;
//   the receiver cannot stall, so nothing waits for it
//   the first point is the one nearest the origin, ties go to the lowest
//   load index; busy falls in the cycle of the final strobe
//   reset (synchronous, active low) empties the set and clears visited flags;
//   the point memory itself is not cleared, only written entries are read
// ----------------------------------------------------------------------------
`include "nearest_neighbour_route_order_defines.svh"

module nearest_neighbour_route_order
    import nnro_pkg::*;
#(
    parameter int POINT_COUNT = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  logic                          i_is_last,
    output logic                          o_valid,
    output logic [IDX_OUT_W-1:0]          o_point_index,
    output logic                          o_last_visit
);

    localparam int IDX_W  = $clog2(POINT_COUNT);
    localparam int CNT_W  = $clog2(POINT_COUNT + 1);
    localparam int DIST_W = 2 * COORD_WIDTH + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SQ_X,
        S_SQ_Y,
        S_CMP,
        S_EMIT
    } t_state;

    t_state                   r_state;
    logic [POINT_COUNT-1:0]   r_visited;
    logic [CNT_W-1:0]         r_loaded;
    logic [CNT_W-1:0]         r_visit;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_found;
    logic signed [COORD_WIDTH-1:0] r_cur_x;
    logic signed [COORD_WIDTH-1:0] r_cur_y;
    logic                     r_o_valid;
    logic [IDX_OUT_W-1:0]     r_o_index;
    logic                     r_o_last;

    // best candidate of the current scan (payload, no reset)
    logic [IDX_W-1:0]              r_best;
    logic [DIST_W-1:0]             r_best_d;
    logic signed [COORD_WIDTH-1:0] r_best_x;
    logic signed [COORD_WIDTH-1:0] r_best_y;

    logic                          w_accept;
    logic                          w_we;
    logic signed [COORD_WIDTH-1:0] w_rd_x;
    logic signed [COORD_WIDTH-1:0] w_rd_y;
    t_dist_op                      w_op;
    logic signed [COORD_WIDTH-1:0] w_a;
    logic signed [COORD_WIDTH-1:0] w_b;
    logic [DIST_W-1:0]             w_dist;
    logic                          w_idx_last;
    logic                          w_final;
    logic                          w_better;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    // store a point only while there is room
    assign w_we     = w_accept && (r_loaded < CNT_W'(POINT_COUNT));

    nnro_point_store #(
        .POINT_COUNT (POINT_COUNT),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_loaded[IDX_W-1:0]),
        .i_wx    (i_x_coord),
        .i_wy    (i_y_coord),
        .i_raddr (r_idx),
        .o_rd_x  (w_rd_x),
        .o_rd_y  (w_rd_y)
    );

    // one squarer serves both axes: x in S_SQ_X, y in S_SQ_Y
    always_comb begin
        case (r_state)
            S_SQ_X:  w_op = DOP_FIRST;
            S_SQ_Y:  w_op = DOP_SECOND;
            default: w_op = DOP_HOLD;
        endcase
    end

    assign w_a = (r_state == S_SQ_Y) ? w_rd_y : w_rd_x;
    assign w_b = (r_state == S_SQ_Y) ? r_cur_y : r_cur_x;

    nnro_sq_dist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .i_clk  (i_clk),
        .i_op   (w_op),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_dist (w_dist)
    );

    assign w_idx_last = (CNT_W'(r_idx) == (r_loaded - CNT_W'(1)));
    assign w_final    = ((r_visit + CNT_W'(1)) == r_loaded);
    // strict compare keeps the lowest index on a tie
    assign w_better   = !r_found || (w_dist < r_best_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_visited <= '0;
            r_loaded  <= '0;
            r_visit   <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_o_valid <= 1'b0;
            r_o_index <= '0;
            r_o_last  <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_we) begin
                            r_loaded <= r_loaded + CNT_W'(1);
                        end
                        if (i_is_last) begin
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // visited points are skipped without touching the squarer
                    if (r_visited[r_idx]) begin
                        if (w_idx_last) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end else begin
                        r_state <= S_SQ_X;
                    end
                end
                S_SQ_X: begin
                    r_state <= S_SQ_Y;
                end
                S_SQ_Y: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_better) begin
                        r_found <= 1'b1;
                    end
                    if (w_idx_last) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_READ;
                    end
                end
                S_EMIT: begin
                    r_o_valid <= 1'b1;
                    r_o_index <= IDX_OUT_W'(r_best);
                    r_o_last  <= w_final;
                    if (w_final) begin
                        // set done: back to an empty set at the origin
                        r_visited <= '0;
                        r_loaded  <= '0;
                        r_visit   <= '0;
                        r_cur_x   <= '0;
                        r_cur_y   <= '0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_visited[r_best] <= 1'b1;
                        r_visit   <= r_visit + CNT_W'(1);
                        r_cur_x   <= r_best_x;
                        r_cur_y   <= r_best_y;
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_state   <= S_READ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_CMP) && w_better) begin
            r_best   <= r_idx;
            r_best_d <= w_dist;
            r_best_x <= w_rd_x;
            r_best_y <= w_rd_y;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_point_index = r_o_index;
    assign o_last_visit  = r_o_last;

    `NNRO_ASSERT_NEXT(a_close_starts_scan, w_accept && i_is_last, r_state == S_READ, "closing item did not start the scan")
    `NNRO_ASSERT_NOW(a_final_frees_block, o_valid && o_last_visit, !busy, "block still busy after final result")
    `NNRO_ASSERT_NOW(a_emit_unvisited, r_state == S_EMIT, r_found && !r_visited[r_best], "emitting a visited or missing point")
    `NNRO_ASSERT_NOW(a_visit_bound, 1'b1, r_visit <= r_loaded, "more visits than loaded points")

endmodule
